// ===== rtl/symbol_name_char_codec_core_defines.svh =====
// assertion macros shared by the checker of the symbol name codec
// needs clk and rst in scope at the point of use
`ifndef SYMBOL_NAME_CHAR_CODEC_CORE_DEFINES_SVH
`define SYMBOL_NAME_CHAR_CODEC_CORE_DEFINES_SVH

// plain clocked assertion, also checked while reset is high
`define SCC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, off while reset is high
`define SCC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/scc_pkg.sv =====
// types, codes and character tables of the symbol name codec
// no dependencies
`timescale 1ns / 1ps

package scc_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNKNOWN_CAP = 2'd1,
    ST_BAD_ESCAPE  = 2'd2,
    ST_OPEN_AT_END = 2'd3
  } status_t;

  typedef enum logic {
    JOB_SINGLE = 1'b0,
    JOB_ESCAPE = 1'b1
  } job_kind_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] ch;
    status_t    status;
    logic       last;
  } job_t;

  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NUL  = 8'h00;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return c inside {[8'h41:8'h5A]};
  endfunction

  function automatic logic is_plain(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h30:8'h39], 8'h49, 8'h57};
  endfunction

  // punctuation to code letter, zero when absent
  function automatic logic [7:0] mangle_map(logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h2D:   m = 8'h5F; // - _
      8'h21:   m = 8'h58; // ! X
      8'h24:   m = 8'h44; // $ D
      8'h25:   m = 8'h50; // % P
      8'h2A:   m = 8'h54; // * T
      8'h2F:   m = 8'h53; // / S
      8'h3C:   m = 8'h4C; // < L
      8'h3E:   m = 8'h47; // > G
      8'h3F:   m = 8'h51; // ? Q
      8'h2B:   m = 8'h41; // + A
      8'h26:   m = 8'h42; // & B
      8'h5E:   m = 8'h43; // ^ C
      8'h5F:   m = 8'h55; // _ U
      8'h40:   m = 8'h4F; // @ O
      8'h3D:   m = 8'h45; // = E
      8'h7E:   m = 8'h4E; // ~ N
      8'h23:   m = 8'h4D; // # M
      default: m = CH_NUL;
    endcase
    return m;
  endfunction

  // code letter back to punctuation, zero when absent
  function automatic logic [7:0] demangle_map(logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h5F:   m = 8'h2D;
      8'h58:   m = 8'h21;
      8'h44:   m = 8'h24;
      8'h50:   m = 8'h25;
      8'h54:   m = 8'h2A;
      8'h53:   m = 8'h2F;
      8'h4C:   m = 8'h3C;
      8'h47:   m = 8'h3E;
      8'h51:   m = 8'h3F;
      8'h41:   m = 8'h2B;
      8'h42:   m = 8'h26;
      8'h43:   m = 8'h5E;
      8'h55:   m = 8'h5F;
      8'h4F:   m = 8'h40;
      8'h45:   m = 8'h3D;
      8'h4E:   m = 8'h7E;
      8'h4D:   m = 8'h23;
      default: m = CH_NUL;
    endcase
    return m;
  endfunction

  // bytes in the escape Z<decimal>Z
  function automatic logic [2:0] esc_len(logic [7:0] c);
    logic [2:0] n;
    n = 3'd3;
    if (c >= 8'd10) n = 3'd4;
    if (c >= 8'd100) n = 3'd5;
    return n;
  endfunction

  // byte k of the escape of c
  function automatic logic [7:0] esc_char(logic [7:0] c, logic [2:0] k);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  o;
    logic [3:0]  d;
    logic [2:0]  n;
    h = (c >= 8'd200) ? 2'd2 : ((c >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(c - 8'(h) * 8'd100);
    // r / 10 by reciprocal, exact for r below 100
    prod = 15'(r) * 15'd205;
    t = prod[14:11];
    o = r - 7'(t) * 7'd10;
    n = esc_len(c);
    if (c >= 8'd100) begin
      d = (k == 3'd1) ? {2'b00, h} : ((k == 3'd2) ? t : o[3:0]);
    end else if (c >= 8'd10) begin
      d = (k == 3'd1) ? t : o[3:0];
    end else begin
      d = o[3:0];
    end
    if (k == 3'd0 || k == n - 3'd1) return CH_Z;
    return CH_ZERO + {4'b0000, d};
  endfunction

endpackage

// ===== rtl/scc_if.sv =====
// stream interfaces of the symbol name codec, input bytes and results
// depends on nothing
`timescale 1ns / 1ps

interface scc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_name;

  modport source (output valid, in_char, end_of_name, input ready);
  modport sink (input valid, in_char, end_of_name, output ready);
endinterface

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       last;

  modport source (output valid, out_char, status, last, input ready);
  modport sink (input valid, out_char, status, last, output ready);
endinterface

// ===== rtl/scc_front.sv =====
// front of the codec: accepts bytes, tracks the open escape, classifies
// each byte into a job for the queue. depends on scc_pkg and scc_if
`timescale 1ns / 1ps

module scc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           direction,
  scc_in_if.sink         sym_in,
  input  logic           q_full,
  output logic           push,
  output scc_pkg::job_t  push_job
);
  import scc_pkg::*;

  logic       esc_open;
  logic       esc_has_digit;
  logic       esc_overflow;
  logic [7:0] esc_value;
  logic       esc_open_next;
  logic       esc_has_digit_next;
  logic       esc_overflow_next;
  logic [7:0] esc_value_next;
  logic       gen;
  job_t       job;
  logic [7:0] c;
  logic       eon;
  logic [7:0] m;
  logic [11:0] v;
  logic       accept;

  assign c = sym_in.in_char;
  assign eon = sym_in.end_of_name;
  assign sym_in.ready = !q_full;
  assign accept = sym_in.valid && !q_full;

  always_comb begin
    esc_open_next      = esc_open;
    esc_has_digit_next = esc_has_digit;
    esc_overflow_next  = esc_overflow;
    esc_value_next     = esc_value;
    gen        = 1'b0;
    job.kind   = JOB_SINGLE;
    job.ch     = CH_NUL;
    job.status = ST_OK;
    job.last   = eon;
    m = CH_NUL;
    v = 12'd0;
    if (!direction) begin
      esc_open_next      = 1'b0;
      esc_has_digit_next = 1'b0;
      esc_overflow_next  = 1'b0;
      esc_value_next     = 8'd0;
      gen = 1'b1;
      m = mangle_map(c);
      if (m != CH_NUL) begin
        job.ch = m;
      end else if (is_plain(c)) begin
        job.ch = c;
      end else begin
        job.kind = JOB_ESCAPE;
        job.ch   = c;
      end
    end else if (esc_open) begin
      if (is_digit(c)) begin
        v = {1'b0, esc_value, 3'b000} + {3'b000, esc_value, 1'b0} + {8'd0, c[3:0]};
        if (v > 12'd255) begin
          esc_overflow_next = 1'b1;
        end else begin
          esc_value_next = v[7:0];
        end
        esc_has_digit_next = 1'b1;
        if (eon) begin
          esc_open_next      = 1'b0;
          esc_has_digit_next = 1'b0;
          esc_overflow_next  = 1'b0;
          esc_value_next     = 8'd0;
          gen = 1'b1;
          job.status = ST_OPEN_AT_END;
        end
      end else begin
        gen = 1'b1;
        if (c == CH_Z && esc_has_digit && !esc_overflow) begin
          job.ch = esc_value;
        end else begin
          job.status = ST_BAD_ESCAPE;
        end
        esc_open_next      = 1'b0;
        esc_has_digit_next = 1'b0;
        esc_overflow_next  = 1'b0;
        esc_value_next     = 8'd0;
      end
    end else if (c == CH_Z) begin
      esc_has_digit_next = 1'b0;
      esc_overflow_next  = 1'b0;
      esc_value_next     = 8'd0;
      if (eon) begin
        esc_open_next = 1'b0;
        gen = 1'b1;
        job.status = ST_OPEN_AT_END;
      end else begin
        esc_open_next = 1'b1;
      end
    end else begin
      m = demangle_map(c);
      if (m != CH_NUL) begin
        gen = 1'b1;
        job.ch = m;
      end else if (is_plain(c)) begin
        gen = 1'b1;
        job.ch = c;
      end else if (is_upper(c)) begin
        gen = 1'b1;
        job.status = ST_UNKNOWN_CAP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_open      <= 1'b0;
      esc_has_digit <= 1'b0;
      esc_overflow  <= 1'b0;
      esc_value     <= 8'd0;
    end else if (accept) begin
      esc_open      <= esc_open_next;
      esc_has_digit <= esc_has_digit_next;
      esc_overflow  <= esc_overflow_next;
      esc_value     <= esc_value_next;
    end
  end

  // bytes that give no result never enter the queue
  assign push = accept && gen;
  assign push_job = job;

endmodule

// ===== rtl/scc_queue.sv =====
// short job queue between front and back of the codec
// depends on scc_pkg
`timescale 1ns / 1ps

module scc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output scc_pkg::job_t head_job
);
  import scc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/scc_back.sv =====
// back of the codec: takes jobs from the queue and delivers results,
// expanding escapes over several transfers. depends on scc_pkg and scc_if
`timescale 1ns / 1ps

module scc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  scc_pkg::job_t head_job,
  output logic          pop,
  scc_out_if.source     sym_out
);
  import scc_pkg::*;

  job_t       job;
  logic       job_valid;
  logic [2:0] step;
  logic       last_step;

  assign last_step = (job.kind == JOB_SINGLE) || (step == esc_len(job.ch) - 3'd1);
  assign pop = !job_valid || (sym_out.ready && last_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      step      <= 3'd0;
    end else if (pop) begin
      job_valid <= head_valid;
      step      <= 3'd0;
    end else if (sym_out.ready) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

  assign sym_out.valid    = job_valid;
  assign sym_out.out_char = (job.kind == JOB_ESCAPE) ? esc_char(job.ch, step) : job.ch;
  assign sym_out.status   = (job.kind == JOB_ESCAPE) ? ST_OK : job.status;
  assign sym_out.last     = job.last && last_step;

endmodule

// ===== rtl/symbol_name_char_codec_core.sv =====
// Symbol name character codec, top level.
// sym_in takes one byte of a name per transfer, with end_of_name on its
// final byte. sym_out gives the converted bytes, each with a status
// (ok, unknown capital, malformed escape, escape open at end) and last
// on the last result of the end_of_name byte. The cfg channel writes direction:
// 0 mangles, 1 demangles. It is always ready; the user must write it
// only while no byte is in flight, as the block does not enforce this.
// A result passes through the job queue and then the job register of
// the back end before it is offered on sym_out.
// Throughput: one byte per cycle when each byte gives one result and
// sym_out is ready. A mangle escape holds the back end while it gives
// its 3 to 5 result bytes; the job queue (QUEUE_DEPTH entries) fills
// meanwhile and then sym_in.ready drops. Bytes that give no result,
// such as digits inside a demangle escape, leave nothing in the queue.
// A stall on sym_out holds the current result; the front keeps taking
// bytes until the queue is full.
// Reset clears direction, the escape state, the queue and the output.
// scc_pkg, scc_if, scc_front, scc_queue, scc_back.
`timescale 1ns / 1ps

module symbol_name_char_codec_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  scc_in_if.sink    sym_in,
  scc_out_if.source sym_out
);
  import scc_pkg::*;

  logic direction;
  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_valid) begin
      direction <= cfg_data;
    end
  end

  scc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .sym_in    (sym_in),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  scc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  scc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .sym_out    (sym_out)
  );

endmodule

// ===== rtl/scc_checker.sv =====
// port level checks of the symbol name codec, bound to the top level
// depends on scc_pkg and the macro header
`timescale 1ns / 1ps
`include "symbol_name_char_codec_core_defines.svh"

module scc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [1:0] out_status,
  input logic       out_last
);
  import scc_pkg::*;

  // reset empties the output and frees the input side
  `SCC_ASSERT_CLK(a_rst_out_idle, rst |=> !out_valid, "output valid after reset")
  `SCC_ASSERT_CLK(a_rst_in_ready, rst |=> in_ready, "input not ready after reset")

  // a result in error carries a zero byte
  `SCC_ASSERT_RUN(a_err_zero, (out_valid && out_status != ST_OK) |-> out_char == CH_NUL, "error result with nonzero byte")

  // a stalled result holds
  `SCC_ASSERT_RUN(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_status) && $stable(out_last)), "stalled result changed")

endmodule

bind symbol_name_char_codec_core scc_checker u_scc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sym_in.ready),
  .out_valid  (sym_out.valid),
  .out_ready  (sym_out.ready),
  .out_char   (sym_out.out_char),
  .out_status (sym_out.status),
  .out_last   (sym_out.last)
);
